@@ rtl/lhl_pkg.sv @@
package lhl_pkg;

   // Line terminator bytes
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Register map: bit 3 of the byte address selects the register
   localparam logic REG_PATTERN = 1'b0;
   localparam logic REG_LENGTH  = 1'b1;

   // Input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic        found;
      logic [15:0] header_offset;
      logic [16:0] line_length;
      logic        overflow;
   } rsp_type;

   // Control handed to every cell of the history row
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // CR-LF or LF-CR
   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      is_pair = ((a == BYTE_CR) && (b == BYTE_LF)) || ((a == BYTE_LF) && (b == BYTE_CR));
   endfunction

endpackage

@@ rtl/lhl_cell.sv @@
module lhl_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lhl_pkg::cell_ctrl_type    ctrl,
   input  logic [7:0]                byte_in,
   input  logic [63:0]               header_pattern,
   input  logic [3:0]                header_length,
   output logic [7:0]                byte_out,
   output logic                      hit,
   output logic                      is_lf
);
   import lhl_pkg::*;

   logic [7:0] hist_ff;
   logic [7:0] hist_in;
   logic [3:0] sel_wide;
   logic [2:0] sel;
   logic [7:0] pat_byte;

   // History byte: shifts along the row, cleared at the end of a buffer
   always_comb begin
      hist_in = hist_ff;
      if (ctrl.clear) begin
         hist_in = '0;
      end else if (ctrl.shift) begin
         hist_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   // Compare the byte arriving here against its header byte (last header byte sits in cell 0)
   always_comb begin
      sel_wide = header_length - 4'(INDEX) - 4'd1;
      sel      = sel_wide[2:0];
      pat_byte = header_pattern[{sel, 3'b000} +: 8];
      hit      = (4'(INDEX) >= header_length) || (byte_in == pat_byte);
      is_lf    = (byte_in == BYTE_LF);
   end

   assign byte_out = hist_ff;

endmodule

@@ rtl/line_header_locator.sv @@
// Line header locator. Takes one byte beat per clock cycle, with no gaps needed
// between buffers; the result beat comes from an output register in the cycle
// after the beat that carries last_byte is taken and may wait there while the
// next buffer streams in; only that buffer's own last_byte beat is held off until
// the waiting result has gone. The rate is set by the row of MAX_HEADER+1 history
// cells, which compare the incoming window against the header combinationally,
// and by the single resolve step that follows them. Program header_pattern
// (address 0) and header_length (address 8) only while no buffer is in flight.
module line_header_locator #(
   parameter int MAX_HEADER = 8,
   parameter int MAX_BUFFER = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lhl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lhl_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);
   import lhl_pkg::*;

   localparam int DEPTH = MAX_HEADER + 1;
   localparam int PW    = $clog2(MAX_BUFFER + 2);
   localparam int CW    = PW + 4;

   // Configuration registers
   logic [63:0] pattern_ff;
   logic [3:0]  length_ff;

   // Stream state
   logic [PW-1:0] pos_ff,  pos_in;
   logic [PW-1:0] ss_ff,   ss_in;
   logic          pend_ff, pend_in;
   logic [PW-1:0] cs_ff,   cs_in;
   logic          cls_ff,  cls_in;
   logic          done_ff, done_in;
   logic [PW-1:0] moff_ff, moff_in;
   logic [PW-1:0] mlen_ff, mlen_in;

   // Output stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   // Cell row
   cell_ctrl_type cell_ctrl;
   logic [7:0]    cell_in  [DEPTH];
   logic [7:0]    cell_out [DEPTH];
   logic [DEPTH-1:0] cell_hit;
   logic [DEPTH-1:0] cell_lf;

   logic          acc;
   logic          at_cap;
   logic [PW-1:0] pos_inc;
   logic          len_ok;
   logic          all_hit;
   logic          lf_at_len;
   logic          inner;
   logic [2:0]    inner_k;
   logic [PW-1:0] p;
   logic          ls;
   logic          found;
   logic [PW+16:0] off_ext;
   logic [PW+16:0] len_ext;

   // APB register port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3])
            REG_PATTERN: pattern_ff <= pwdata;
            REG_LENGTH:  length_ff  <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         REG_PATTERN: prdata = pattern_ff;
         REG_LENGTH:  prdata = {60'd0, length_ff};
         default:     prdata = '0;
      endcase
   end

   // Handshake: only a last beat has to wait for the output register
   assign acc       = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_data.last_byte;

   assign cell_ctrl.shift = acc;
   assign cell_ctrl.clear = acc && req_data.last_byte;

   // History row: cell 0 takes the new byte
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign cell_in[g] = req_data.data_byte;
         end else begin : g_body
            assign cell_in[g] = cell_out[g-1];
         end
         lhl_cell #(.INDEX(g)) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (cell_ctrl),
            .byte_in        (cell_in[g]),
            .header_pattern (pattern_ff),
            .header_length  (length_ff),
            .byte_out       (cell_out[g]),
            .hit            (cell_hit[g]),
            .is_lf          (cell_lf[g])
         );
      end
   endgenerate

   // Window match, LF before the header, first pair inside the header
   always_comb begin
      all_hit   = &cell_hit;
      lf_at_len = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
         if (length_ff == 4'(j)) begin
            lf_at_len = cell_lf[j];
         end
      end
      inner   = 1'b0;
      inner_k = '0;
      for (int k = 6; k >= 0; k--) begin
         if ((4'(k + 1) < length_ff) &&
             is_pair(pattern_ff[k*8 +: 8], pattern_ff[(k+1)*8 +: 8])) begin
            inner   = 1'b1;
            inner_k = 3'(k);
         end
      end
   end

   assign len_ok = (length_ff != 4'd0) && (length_ff <= 4'(MAX_HEADER));

   // Resolve step
   always_comb begin
      at_cap  = pos_ff >= PW'(MAX_BUFFER);
      pos_inc = at_cap ? PW'(MAX_BUFFER + 1) : pos_ff + PW'(1);
      ss_in   = ss_ff;
      pend_in = pend_ff;
      cs_in   = cs_ff;
      cls_in  = cls_ff;
      done_in = done_ff;
      moff_in = moff_ff;
      mlen_in = mlen_ff;
      p       = pos_inc - PW'(length_ff);
      ls      = 1'b0;
      if (!at_cap && !done_ff) begin
         // pending header meets its terminator
         if (pend_ff && (pos_ff != '0) && is_pair(cell_out[0], req_data.data_byte)) begin
            pend_in = 1'b0;
            if (cls_ff) begin
               done_in = 1'b1;
               moff_in = cs_ff;
               mlen_in = pos_inc - cs_ff;
            end else begin
               ss_in = pos_inc;
            end
         end
         // new header occurrence ending on this byte
         if (!pend_in && !done_in && len_ok && (CW'(pos_inc) >= CW'(length_ff))) begin
            if ((p >= ss_in) && all_hit) begin
               ls = (p == ss_in) || lf_at_len;
               if (inner) begin
                  if (ls) begin
                     done_in = 1'b1;
                     moff_in = p;
                     mlen_in = PW'(inner_k) + PW'(2);
                  end else begin
                     ss_in = p + PW'(inner_k) + PW'(2);
                  end
               end else begin
                  pend_in = 1'b1;
                  cs_in   = p;
                  cls_in  = ls;
               end
            end
         end
      end
      pos_in = pos_inc;
   end

   // Result beat
   always_comb begin
      found                     = done_in && !at_cap;
      off_ext                   = {17'd0, moff_in};
      len_ext                   = {17'd0, mlen_in};
      rsp_data_in.found         = found;
      rsp_data_in.header_offset = found ? off_ext[15:0] : 16'd0;
      rsp_data_in.line_length   = found ? len_ext[16:0] : 17'd0;
      rsp_data_in.overflow      = at_cap;
      rsp_valid_in              = rsp_valid_ff;
      if (acc && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ss_ff        <= '0;
         pend_ff      <= 1'b0;
         cs_ff        <= '0;
         cls_ff       <= 1'b0;
         done_ff      <= 1'b0;
         moff_ff      <= '0;
         mlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (acc && req_data.last_byte) begin
            pos_ff  <= '0;
            ss_ff   <= '0;
            pend_ff <= 1'b0;
            cs_ff   <= '0;
            cls_ff  <= 1'b0;
            done_ff <= 1'b0;
            moff_ff <= '0;
            mlen_ff <= '0;
         end else if (acc) begin
            pos_ff  <= pos_in;
            ss_ff   <= ss_in;
            pend_ff <= pend_in;
            cs_ff   <= cs_in;
            cls_ff  <= cls_in;
            done_ff <= done_in;
            moff_ff <= moff_in;
            mlen_ff <= mlen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_found_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.overflow))
      else $error("found and overflow both set");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.header_offset == 16'd0 &&
                                          rsp_data.line_length == 17'd0))
      else $error("offset or length set without a match");

   a_done_no_pend: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !pend_ff)
      else $error("candidate pending after a match");

   a_pos_cap: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(MAX_BUFFER + 1))
      else $error("byte count beyond saturation");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.last_byte) |=> (pos_ff == '0 && !done_ff && rsp_valid_ff))
      else $error("stream state not cleared after last beat");
`endif

endmodule
